@@ hdl/b32d_pkg.sv @@
// Shared types, character codes and sizes for the Base32 text decoder.
package b32d_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int SYM_W   = 5;
    localparam int ACC_W   = 12;
    localparam int HELD_W  = 3;
    localparam int COUNT_W = 13;
    localparam int BYTE_W  = 8;

    localparam int COUNT_MAX      = (2 ** COUNT_W) - 1;
    localparam int BYTE_LIMIT_DEF = 4096;

    // Character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQUALS     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_2    = 8'h32;
    localparam logic [CHAR_W-1:0] CH_DIGIT_7    = 8'h37;
    // '2' maps to symbol 26
    localparam logic [CHAR_W-1:0] DIGIT_BIAS    = 8'd24;
    localparam logic [SYM_W-1:0]  LETTER_BIAS   = 5'd1;

    // Character classes
    typedef enum logic [1:0] {
        CLS_SYM  = 2'd0,
        CLS_SKIP = 2'd1,
        CLS_END  = 2'd2,
        CLS_BAD  = 2'd3
    } t_class;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One input item
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              first;
    } t_item;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        t_kind              kind;
        logic [COUNT_W-1:0] byte_count;
        logic               full_res;
    } t_result;

endpackage

@@ hdl/base32_text_decoder.sv @@
// An accepted item passes through the input register and then the result register before its result shows on o_m_*.
// Throughput: one character per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Skipped and ignored characters pass through without producing a result item.
// Reset (i_rst_n low at a clock edge) clears the decode state, both valid flags,
// and sets max_bytes to the byte limit clipped to 8191.
module base32_text_decoder
    import b32d_pkg::*;
#(
    parameter int BYTE_LIMIT = BYTE_LIMIT_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character items
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] char_in
    input  logic               i_s_tuser,   // [0] first
    // result items
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [23:0]        o_m_tdata,   // [7:0] data_byte, [20:8] byte_count,
                                            // [21] full_res, [23:22] zero
    output logic [1:0]         o_m_tuser,   // [1:0] kind
    // configuration
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata  // max_bytes
);

    localparam logic [COUNT_W-1:0] MAX_RESET =
        (BYTE_LIMIT > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(BYTE_LIMIT);

    logic               r_in_valid;
    t_item              r_in;
    logic               r_out_valid;
    t_result            r_out;
    logic [COUNT_W-1:0] r_max_bytes;
    logic               advance;
    logic               res_valid;
    t_result            res;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_RESET;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.char_in <= i_s_tdata;
            r_in.first   <= i_s_tuser;
        end
    end

    b32d_core #(
        .BYTE_LIMIT (BYTE_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_in_valid && advance),
        .i_item      (r_in),
        .i_max_bytes (r_max_bytes),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.full_res, r_out.byte_count, r_out.data_byte};
    assign o_m_tuser  = r_out.kind;

endmodule

@@ hdl/b32d_classify.sv @@
// Character classifier: sorts a text character and maps Base32 symbols to 0..31.
module b32d_classify
    import b32d_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    output t_class            o_class,
    output logic [SYM_W-1:0]  o_sym
);

    logic is_letter;
    logic is_digit;
    logic [CHAR_W-1:0] digit_val;

    assign is_letter = ((i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_Z)) ||
                       ((i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_Z));
    assign is_digit  = (i_char >= CH_DIGIT_2) && (i_char <= CH_DIGIT_7);
    assign digit_val = i_char - DIGIT_BIAS;

    // Sort the character and derive its symbol value
    always_comb begin
        o_sym = '0;
        case (i_char)
            CH_SPACE, CH_UNDERSCORE, CH_TAB, CH_CR, CH_LF, CH_MINUS, CH_PLUS: begin
                o_class = CLS_SKIP;
            end
            CH_EQUALS, CH_NUL: begin
                o_class = CLS_END;
            end
            default: begin
                if (is_letter) begin
                    o_class = CLS_SYM;
                    o_sym   = i_char[SYM_W-1:0] - LETTER_BIAS;
                end else if (is_digit) begin
                    o_class = CLS_SYM;
                    o_sym   = digit_val[SYM_W-1:0];
                end else begin
                    o_class = CLS_BAD;
                end
            end
        endcase
    end

endmodule

@@ hdl/b32d_core.sv @@
// Decode state and per-item step: bit accumulator, counts, stop flag, result build.
module b32d_core
    import b32d_pkg::*;
#(
    parameter int BYTE_LIMIT = BYTE_LIMIT_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_item              i_item,
    input  logic [COUNT_W-1:0] i_max_bytes,
    output logic               o_res_valid,
    output t_result            o_res
);

    localparam logic [COUNT_W-1:0] LIMIT_CLIP =
        (BYTE_LIMIT > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(BYTE_LIMIT);
    localparam logic [HELD_W:0] HELD_STEP = (HELD_W + 1)'(SYM_W);
    localparam logic [HELD_W:0] HELD_BYTE = (HELD_W + 1)'(BYTE_W);

    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [HELD_W-1:0]  r_held,  n_held;
    logic [COUNT_W-1:0] r_done,  n_done;
    logic               r_stopped, n_stopped;

    logic [ACC_W-1:0]   acc0;
    logic [HELD_W-1:0]  held0;
    logic [COUNT_W-1:0] done0;
    logic               stop0;
    logic [COUNT_W-1:0] limit;
    logic               blocked;
    t_class             cls;
    logic [SYM_W-1:0]   sym;
    logic [ACC_W-1:0]   acc_sh;
    logic [HELD_W:0]    held_sum;
    logic [HELD_W:0]    shift;
    logic [ACC_W-1:0]   acc_out;
    logic [COUNT_W-1:0] done_inc;

    b32d_classify u_classify (
        .i_char  (i_item.char_in),
        .o_class (cls),
        .o_sym   (sym)
    );

    // Start-of-string clear and effective byte limit
    assign acc0    = i_item.first ? '0 : r_acc;
    assign held0   = i_item.first ? '0 : r_held;
    assign done0   = i_item.first ? '0 : r_done;
    assign stop0   = i_item.first ? 1'b0 : r_stopped;
    assign limit   = (i_max_bytes > LIMIT_CLIP) ? LIMIT_CLIP : i_max_bytes;
    assign blocked = stop0 || (done0 >= limit);

    // Shift in one symbol and pick the top eight valid bits
    assign acc_sh   = {acc0[ACC_W-SYM_W-1:0], sym};
    assign held_sum = {1'b0, held0} + HELD_STEP;
    assign shift    = held_sum - HELD_BYTE;
    assign acc_out  = acc_sh >> shift;
    assign done_inc = done0 + 1'b1;

    // Next state and result
    always_comb begin
        n_acc       = acc0;
        n_held      = held0;
        n_done      = done0;
        n_stopped   = stop0;
        o_res_valid = 1'b0;
        o_res.data_byte  = '0;
        o_res.kind       = KIND_BYTE;
        o_res.byte_count = done0;
        o_res.full_res   = (done0 >= limit);
        if (!blocked) begin
            case (cls)
                CLS_SYM: begin
                    n_acc = acc_sh;
                    if (held_sum >= HELD_BYTE) begin
                        n_held           = shift[HELD_W-1:0];
                        n_done           = done_inc;
                        o_res_valid      = 1'b1;
                        o_res.data_byte  = acc_out[BYTE_W-1:0];
                        o_res.byte_count = done_inc;
                        o_res.full_res   = (done_inc >= limit);
                    end else begin
                        n_held = held_sum[HELD_W-1:0];
                    end
                end
                CLS_END: begin
                    n_stopped   = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_END;
                end
                CLS_BAD: begin
                    n_stopped   = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERR;
                end
                default: begin
                    // skipped character: state holds
                end
            endcase
        end
    end

    // State registers, advanced once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_held    <= '0;
            r_done    <= '0;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_done    <= n_done;
            r_stopped <= n_stopped;
        end
    end

    // A stop result leaves the decoder stopped
    a_stop_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && (o_res.kind != KIND_BYTE)) |=> r_stopped)
        else $error("stop result did not set stop flag");

    // A byte result carries the new byte count
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && (o_res.kind == KIND_BYTE))
            |=> (r_done == $past(o_res.byte_count)))
        else $error("byte count out of step with result");

    // Non-byte results carry a zero data byte
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind != KIND_BYTE)) |-> (o_res.data_byte == '0))
        else $error("end or error result with nonzero data");

    // A stopped decoder without a new string gives nothing
    a_quiet_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !i_item.first) |-> !o_res_valid)
        else $error("result while stopped");

endmodule

@@ test/base32_text_decoder_tb.sv @@
// Self-checking testbench for the Base32 text decoder with a predicting scoreboard.
`timescale 1ns / 100ps

module base32_text_decoder_tb;
    import b32d_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 180;
    localparam int PHASES       = 6;

    localparam logic [CHAR_W-1:0] SKIP_CHARS [0:6] = '{
        CH_SPACE, CH_UNDERSCORE, CH_TAB, CH_CR, CH_LF, CH_MINUS, CH_PLUS
    };

    // Predict decoded bytes and hold them until the block hands them out
    class base32_byte_scoreboard;
        logic [COUNT_W-1:0] max_bytes;
        logic [ACC_W-1:0]   bit_acc;
        int unsigned        bits_held;
        logic [COUNT_W-1:0] bytes_done;
        bit                 stopped;
        t_result            pending_results[$];
        int unsigned        fails;

        function new();
            max_bytes  = (BYTE_LIMIT_DEF > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                      : BYTE_LIMIT_DEF[COUNT_W-1:0];
            bit_acc    = '0;
            bits_held  = 0;
            bytes_done = '0;
            stopped    = 1'b0;
            fails      = 0;
        endfunction

        function void set_limit(logic [COUNT_W-1:0] value);
            max_bytes = value;
        endfunction

        function void push_result(logic [BYTE_W-1:0] data, t_kind kind, int unsigned limit_now);
            t_result r;
            r.data_byte  = data;
            r.kind       = kind;
            r.byte_count = bytes_done;
            r.full_res   = (bytes_done >= limit_now);
            pending_results.push_back(r);
        endfunction

        // Advance the decode state by one accepted character item
        function void note_char(logic [CHAR_W-1:0] c, logic first_flag);
            int unsigned        limit_now;
            logic [SYM_W-1:0]   sym;
            logic [CHAR_W-1:0]  shifted;
            logic [ACC_W-1:0]   aligned;
            if (first_flag) begin
                bit_acc    = '0;
                bits_held  = 0;
                bytes_done = '0;
                stopped    = 1'b0;
            end
            limit_now = (max_bytes > BYTE_LIMIT_DEF) ? BYTE_LIMIT_DEF : max_bytes;
            if (stopped || bytes_done >= limit_now)
                return;
            case (c)
                CH_SPACE, CH_UNDERSCORE, CH_TAB, CH_CR, CH_LF, CH_MINUS, CH_PLUS: return;
                CH_EQUALS, CH_NUL: begin
                    stopped = 1'b1;
                    push_result('0, KIND_END, limit_now);
                    return;
                end
                default: ;
            endcase
            if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
                sym = c[SYM_W-1:0] - LETTER_BIAS;
            end else if (c >= CH_DIGIT_2 && c <= CH_DIGIT_7) begin
                shifted = c - DIGIT_BIAS;
                sym     = shifted[SYM_W-1:0];
            end else begin
                stopped = 1'b1;
                push_result('0, KIND_ERR, limit_now);
                return;
            end
            bit_acc   = {bit_acc[ACC_W-SYM_W-1:0], sym};
            bits_held = bits_held + SYM_W;
            if (bits_held >= BYTE_W) begin
                bits_held  = bits_held - BYTE_W;
                bytes_done = bytes_done + 1'b1;
                aligned    = bit_acc >> bits_held;
                push_result(aligned[BYTE_W-1:0], KIND_BYTE, limit_now);
            end
        endfunction

        // Compare one result item against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: data_byte %0h kind %0d byte_count %0d",
                       got.data_byte, got.kind, got.byte_count);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte mismatch: expected %0h, actual %0h",
                       want.data_byte, got.data_byte);
                fails++;
            end
            if (got.kind !== want.kind) begin
                $error("kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
                fails++;
            end
            if (got.byte_count !== want.byte_count) begin
                $error("byte_count mismatch: expected %0d, actual %0d",
                       want.byte_count, got.byte_count);
                fails++;
            end
            if (got.full_res !== want.full_res) begin
                $error("full_res mismatch: expected %0d, actual %0d",
                       want.full_res, got.full_res);
                fails++;
            end
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               s_tvalid   = 1'b0;
    logic [7:0]         s_tdata    = '0;
    logic               s_tuser    = 1'b0;
    logic               m_tready   = 1'b1;
    logic               cfg_we     = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata  = '0;
    logic               s_tready;
    logic               m_tvalid;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;

    bit                 gaps_on    = 1'b1;
    bit                 ready_idle = 1'b1;
    bit                 hold_req   = 1'b0;
    int unsigned        items_sent = 0;
    int unsigned        cycle_count = 0;

    base32_byte_scoreboard board = new();

    base32_text_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Take result items and check them
    always @(posedge clk) begin : take_result
        t_result got;
        if (rst_n && m_tvalid && m_tready) begin
            got.data_byte  = m_tdata[7:0];
            got.byte_count = m_tdata[20:8];
            got.full_res   = m_tdata[21];
            got.kind       = t_kind'(m_tuser);
            board.check_result(got);
        end
    end

    // Drive the result ready: random stalls, one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (ready_idle && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one character item and wait until it is taken
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic first_flag);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= first_flag;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_char(c, first_flag);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_limit(value);
    endtask

    function automatic logic [CHAR_W-1:0] pick_symbol();
        int unsigned       r;
        logic [CHAR_W-1:0] base;
        r = $urandom_range(0, 31);
        if (r < 26) begin
            base = $urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A;
            return base + CHAR_W'(r);
        end
        return CH_DIGIT_2 + CHAR_W'(r - 26);
    endfunction

    // Send one string of random symbols and skip characters, ending in '=', NUL, a random character or nothing
    task automatic send_random_text();
        int unsigned len;
        int unsigned ending;
        logic        lead;
        lead = 1'b1;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
        repeat (len) begin
            if ($urandom_range(0, 99) < 8)
                send_char(SKIP_CHARS[$urandom_range(0, 6)], lead);
            else
                send_char(pick_symbol(), lead);
            lead = 1'b0;
        end
        ending = $urandom_range(0, 9);
        if (ending < 5)
            send_char(CH_EQUALS, 1'b0);
        else if (ending < 7)
            send_char(CH_NUL, 1'b0);
        else if (ending < 8)
            send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin : stimulus
        logic [COUNT_W-1:0] limits [0:PHASES-1];
        int unsigned        target;

        limits[0] = COUNT_W'(BYTE_LIMIT_DEF);
        limits[1] = 13'd1;
        limits[2] = COUNT_W'($urandom_range(2, 16));
        limits[3] = COUNT_W'(COUNT_MAX);
        limits[4] = COUNT_W'($urandom_range(17, 300));
        limits[5] = 13'd3;

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Alphabet edges, skip characters, end, stop and bad neighbors
        send_char(CH_UPPER_A, 1'b1);
        send_char(CH_LOWER_Z, 1'b0);
        send_char(CH_DIGIT_2, 1'b0);
        send_char(CH_DIGIT_7, 1'b0);
        foreach (SKIP_CHARS[k]) send_char(SKIP_CHARS[k], 1'b0);
        send_char(CH_UPPER_Z, 1'b0);
        send_char(CH_LOWER_A, 1'b0);
        send_char(CH_EQUALS, 1'b0);
        send_char(CH_UPPER_A, 1'b0);
        send_char(CH_NUL, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CH_DIGIT_2 - 1'b1, 1'b1);
        send_char(CH_DIGIT_7 + 1'b1, 1'b1);
        send_char(CH_UPPER_A - 1'b1, 1'b1);
        send_char(CH_LOWER_Z + 1'b1, 1'b1);
        drain();

        // Limit of one byte: the end character after it is ignored
        write_limit(13'd1);
        send_char(CH_UPPER_A + 8'd12, 1'b1);
        send_char(CH_UPPER_Z, 1'b0);
        send_char(CH_EQUALS, 1'b0);
        drain();

        // Zero limit ignores everything
        write_limit(13'd0);
        send_char(CH_UPPER_A, 1'b1);
        send_char(CH_EQUALS, 1'b0);
        drain();

        // Random phases over several limits
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            if (p == 0)
                hold_req = 1'b1;
            if (p == PHASES - 1) begin
                gaps_on    = 1'b0;
                ready_idle = 1'b0;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0)
                    send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_random_text();
            end
            drain();
        end

        if (board.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/b32d_pkg.sv
hdl/b32d_classify.sv
hdl/b32d_core.sv
hdl/base32_text_decoder.sv
test/base32_text_decoder_tb.sv
